// ----- design/pha_pkg.sv -----
package pha_pkg;

    localparam int MAX_BINS_DEF = 256;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] slant;
        logic signed [23:0] energy_loss;
        logic [7:0]         bin_index;
    } t_in;

    typedef struct packed {
        logic signed [8:0]  bin_hit;
        logic [15:0]        bin_entries;
        logic signed [39:0] bin_sum;
        logic [63:0]        bin_sum_squares;
        logic signed [23:0] bin_mean;
        logic [31:0]        total_entries;
        logic signed [47:0] total_sum;
        logic [31:0]        positive_losses;
        logic signed [23:0] overall_mean;
    } t_out;

    localparam logic [1:0] REG_RANGE_LOW = 2'd0;
    localparam logic [1:0] REG_BIN_WIDTH = 2'd1;
    localparam logic [1:0] REG_BINS      = 2'd2;

    localparam logic KIND_FILL = 1'b0;

    // Request to the shared divider and its answer.
    typedef struct packed {
        logic        start;
        logic [47:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_BIN_DIV, ST_BIN_WAIT, ST_UPD_RD, ST_UPD_SQ,
        ST_UPD_WR, ST_MEAN1, ST_MEAN1_W, ST_MEAN2, ST_MEAN2_W, ST_OUT
    } t_state;

endpackage

// ----- design/pha_div.sv -----
module pha_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pha_pkg::t_div_req i_req,
    output pha_pkg::t_div_rsp o_rsp
);
    import pha_pkg::*;

    logic [47:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy, r_done, n_done;
    logic [32:0] w_trial;

    // One quotient bit per cycle, restoring division.
    always_comb begin
        w_trial = {r_rem, r_quo[47]} - {1'b0, r_den};
        n_quo = r_quo;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo = i_req.num;
            n_rem = '0;
            n_cnt = 6'd48;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[46:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[47]};
                n_quo = {r_quo[46:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo = r_quo;
endmodule

// ----- design/profile_histogram_accumulator_unit.sv -----
// Profile histogram with per-bin count, sum and sum of squares, plus running
// totals. One item is in flight at a time, and it makes two passes in turn
// through the 48-step serial divider. A fill finds its bin number and then the
// overall mean; a fill whose sample is dropped skips the bin update. A read
// finds the bin mean and then the overall mean. A mean pass whose divisor is
// zero is skipped. The next item is taken only once the result has been
// transferred. After reset a clearing pass sweeps the bin memory, during which
// no item is taken.
module profile_histogram_accumulator_unit #(
    parameter int MAX_BINS = pha_pkg::MAX_BINS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pha_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output pha_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);
    import pha_pkg::*;

    localparam int AW = $clog2(MAX_BINS);
    localparam int NBW = $clog2(MAX_BINS + 1);

    logic signed [31:0] r_low;
    logic [30:0]        r_width;
    logic [8:0]         r_bins;

    t_state r_st, n_st;
    t_in    r_item;
    t_out   r_out;
    logic   r_ovalid;

    logic [15:0] mem_cnt [MAX_BINS];
    logic [39:0] mem_sum [MAX_BINS];
    logic [63:0] mem_sq  [MAX_BINS];
    logic [15:0] r_rc;
    logic signed [39:0] r_rs;
    logic [63:0] r_rq;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_clr;
    logic          r_inrange;
    logic [47:0]   r_sqv;
    logic [31:0]   r_tent, r_tpos;
    logic signed [47:0] r_tsum;
    logic          r_neg;

    t_div_req w_req;
    t_div_rsp w_rsp;

    pha_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req), .o_rsp(w_rsp));

    // Effective bin count and range test operands.
    logic [NBW-1:0]     w_nb;
    logic signed [33:0] w_d;
    logic [47:0]        w_span;
    always_comb begin
        if ({23'd0, r_bins} > 32'(MAX_BINS)) w_nb = NBW'(MAX_BINS);
        else w_nb = NBW'(r_bins);
        w_d = 34'(r_item.slant) - 34'(r_low);
    end
    always_ff @(posedge i_clk) w_span <= 48'(w_nb) * 48'(r_width);

    // Signed division through the unsigned divider.
    logic [47:0] w_num;
    logic [31:0] w_den;
    logic        w_nneg;
    always_comb begin
        w_num = '0;
        w_den = 32'(r_width);
        w_nneg = 1'b0;
        if (r_st == ST_MEAN1) begin
            w_nneg = r_rs[39];
            w_num = r_rs[39] ? -48'(r_rs) : 48'(r_rs);
            w_den = 32'(r_rc);
        end else if (r_st == ST_MEAN2) begin
            w_nneg = r_tsum[47];
            w_num = r_tsum[47] ? -r_tsum : r_tsum;
            w_den = r_tent;
        end else begin
            w_num = 48'(w_d[32:0]);
        end
        w_req.start = (r_st == ST_BIN_DIV) || (r_st == ST_MEAN1) || (r_st == ST_MEAN2);
        w_req.num = w_num;
        w_req.den = w_den;
    end

    function automatic logic [23:0] sat_mean(input logic [47:0] q, input logic neg);
        logic [23:0] res;
        if (!neg) res = (q > 48'd8388607) ? 24'h7fffff : q[23:0];
        else res = (q > 48'd8388608) ? 24'h800000 : 24'(-q);
        return res;
    endfunction

    // Next state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_CLEAR:    if (r_clr == AW'(MAX_BINS - 1)) n_st = ST_IDLE;
            ST_IDLE:     if (i_valid && o_ready) n_st = ST_RD;
            ST_RD:       n_st = (r_item.kind == KIND_FILL) ? ST_BIN_DIV : ST_MEAN1;
            ST_BIN_DIV:  n_st = ST_BIN_WAIT;
            ST_BIN_WAIT: if (w_rsp.done) n_st = r_inrange ? ST_UPD_RD : ST_MEAN2;
            ST_UPD_RD:   n_st = ST_UPD_SQ;
            ST_UPD_SQ:   n_st = ST_UPD_WR;
            ST_UPD_WR:   n_st = ST_MEAN2;
            ST_MEAN1:    n_st = (r_rc == 16'd0) ? ST_MEAN2 : ST_MEAN1_W;
            ST_MEAN1_W:  if (w_rsp.done) n_st = ST_MEAN2;
            ST_MEAN2:    n_st = (r_tent == 32'd0) ? ST_OUT : ST_MEAN2_W;
            ST_MEAN2_W:  if (w_rsp.done) n_st = ST_OUT;
            ST_OUT:      n_st = ST_IDLE;
            default:     n_st = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_ready = (r_st == ST_IDLE) && !r_ovalid;
    end

    logic [7:0] w_ri;
    assign w_ri = r_item.bin_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_low <= '0;
            r_width <= 31'd4096;
            r_bins <= 9'd256;
            r_tent <= '0;
            r_tpos <= '0;
            r_tsum <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RANGE_LOW: r_low <= i_cfg_data;
                    REG_BIN_WIDTH: r_width <= i_cfg_data[30:0];
                    REG_BINS:      r_bins <= i_cfg_data[8:0];
                    default: ;
                endcase
            end
            if (r_st == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (r_st == ST_OUT) r_ovalid <= 1'b1;
            if (r_st == ST_UPD_WR) begin
                if (r_tent != 32'hffffffff) r_tent <= r_tent + 32'd1;
                if (!r_item.energy_loss[23] && r_item.energy_loss != 24'd0
                    && r_tpos != 32'hffffffff) r_tpos <= r_tpos + 32'd1;
                begin
                    logic signed [48:0] s;
                    s = 49'(r_tsum) + 49'(r_item.energy_loss);
                    if (s > 49'sd140737488355327) r_tsum <= 48'h7fffffffffff;
                    else if (s < -49'sd140737488355328) r_tsum <= 48'h800000000000;
                    else r_tsum <= s[47:0];
                end
            end
        end
    end

    // Datapath and memories.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_CLEAR) begin
            mem_cnt[r_clr] <= '0;
            mem_sum[r_clr] <= '0;
            mem_sq[r_clr] <= '0;
        end
        if (o_ready && i_valid) r_item <= i_data;
        case (r_st)
            ST_RD: begin
                r_inrange <= 1'b0;
                r_out <= '0;
                r_neg <= 1'b0;
                if (MAX_BINS >= 256 || 32'(w_ri) < 32'(MAX_BINS)) begin
                    r_rc <= mem_cnt[AW'(w_ri)];
                    r_rs <= mem_sum[AW'(w_ri)];
                    r_rq <= mem_sq[AW'(w_ri)];
                end else begin
                    r_rc <= '0;
                    r_rs <= '0;
                    r_rq <= '0;
                end
            end
            ST_BIN_DIV: begin
                r_inrange <= (r_width != 31'd0) && (w_nb != '0) && !w_d[33]
                             && ({14'd0, w_d} < w_span);
                r_out.bin_hit <= 9'h1ff;
            end
            ST_BIN_WAIT: if (w_rsp.done) begin
                r_addr <= (w_rsp.quo >= 48'(MAX_BINS)) ? AW'(MAX_BINS - 1) : AW'(w_rsp.quo);
                if (r_inrange) r_out.bin_hit <= (w_rsp.quo >= 48'(MAX_BINS)) ?
                    9'(MAX_BINS - 1) : w_rsp.quo[8:0];
            end
            ST_UPD_RD: begin
                r_rc <= mem_cnt[r_addr];
                r_rs <= mem_sum[r_addr];
                r_rq <= mem_sq[r_addr];
                r_sqv <= 48'($signed(r_item.energy_loss) * $signed(r_item.energy_loss));
            end
            ST_UPD_SQ: begin
                if (r_rc != 16'hffff) r_rc <= r_rc + 16'd1;
                begin
                    logic signed [40:0] s;
                    logic [64:0] q;
                    s = 41'(r_rs) + 41'(r_item.energy_loss);
                    if (s > 41'sd549755813887) r_rs <= 40'h7fffffffff;
                    else if (s < -41'sd549755813888) r_rs <= 40'h8000000000;
                    else r_rs <= s[39:0];
                    q = 65'(r_rq) + 65'(r_sqv);
                    r_rq <= q[64] ? 64'hffffffffffffffff : q[63:0];
                end
            end
            ST_UPD_WR: begin
                mem_cnt[r_addr] <= r_rc;
                mem_sum[r_addr] <= r_rs;
                mem_sq[r_addr] <= r_rq;
            end
            ST_MEAN1: begin
                r_neg <= w_nneg;
                r_out.bin_entries <= r_rc;
                r_out.bin_sum <= r_rs;
                r_out.bin_sum_squares <= r_rq;
                r_out.bin_mean <= '0;
            end
            ST_MEAN1_W: if (w_rsp.done) r_out.bin_mean <= sat_mean(w_rsp.quo, r_neg);
            ST_MEAN2: begin
                r_neg <= w_nneg;
                r_out.total_entries <= r_tent;
                r_out.total_sum <= r_tsum;
                r_out.positive_losses <= r_tpos;
                r_out.overall_mean <= '0;
            end
            ST_MEAN2_W: if (w_rsp.done) r_out.overall_mean <= sat_mean(w_rsp.quo, r_neg);
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data = r_out;
endmodule

// ----- design/pha_checker.sv -----
module pha_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input pha_pkg::t_out o_data
);
    // A stalled result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("result changed");

    // No input transfer while a result waits.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready with pending result");

    // Taking an item drops ready next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready while busy");

    // Nothing valid straight after reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
endmodule

bind profile_histogram_accumulator_unit pha_checker u_chk (.*);

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pha_pkg::*;

    localparam int NBINS = 256;
    localparam longint CYCLE_LIMIT = 3000000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    t_in           i_data;
    logic          o_valid;
    logic          i_ready;
    t_out          o_data;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_idx;
    logic [31:0]   i_cfg_data;

    profile_histogram_accumulator_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // Shadow histogram state.
    logic [15:0]        bin_count [NBINS];
    logic signed [39:0] bin_total [NBINS];
    logic [63:0]        bin_square [NBINS];
    logic [31:0]        n_taken;
    logic signed [47:0] sum_taken;
    logic [31:0]        n_positive;
    logic signed [31:0] edge_low;
    logic [30:0]        width_q;
    logic [8:0]         nbins_q;

    t_in  sample_queue [$];
    t_out expected_queue [$];
    int   mismatches = 0;
    int   fills_hit = 0;
    int   fills_missed = 0;
    int   reads_done = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    longint cycles = 0;

    // Appends one item to the end of the pending queue.
    function automatic void add_item(t_in it);
        sample_queue.insert(sample_queue.size(), it);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Truncating mean, clamped to 24 bits, zero for no samples.
    function automatic logic signed [23:0] clamp_mean(longint sum, longint n);
        longint q;
        if (n == 0) return '0;
        q = sum / n;
        if (q > 64'sd8388607) q = 8388607;
        if (q < -64'sd8388608) q = -8388608;
        return q[23:0];
    endfunction

    function automatic longint clamp_add(longint a, longint b, longint lo, longint hi);
        longint s;
        s = a + b;
        if (s > hi) return hi;
        if (s < lo) return lo;
        return s;
    endfunction

    // Applies one transfer to the shadow state and returns the predicted result.
    function automatic t_out histogram_step(t_in it);
        t_out   r;
        longint d, span, y, b;
        logic [63:0] sq;
        longint nb;
        r = '0;
        if (it.kind == KIND_FILL) begin
            nb = (nbins_q > NBINS) ? NBINS : nbins_q;
            d = longint'(it.slant) - longint'(edge_low);
            span = nb * longint'(width_q);
            y = longint'(it.energy_loss);
            r.bin_hit = -9'sd1;
            if (width_q != 0 && nb != 0 && d >= 0 && d < span) begin
                b = d / longint'(width_q);
                if (b >= NBINS) b = NBINS - 1;
                sq = y * y;
                if (bin_count[b] != 16'hFFFF) bin_count[b] = bin_count[b] + 1;
                bin_total[b] = clamp_add(bin_total[b], y, -64'sd549755813888,
                                         64'sd549755813887);
                bin_square[b] = (bin_square[b] + sq < bin_square[b]) ? '1
                                : bin_square[b] + sq;
                if (n_taken != '1) n_taken = n_taken + 1;
                sum_taken = clamp_add(sum_taken, y, -64'sd140737488355328,
                                      64'sd140737488355327);
                if (y > 0 && n_positive != '1) n_positive = n_positive + 1;
                r.bin_hit = b[8:0];
            end
        end else begin
            r.bin_entries = bin_count[it.bin_index];
            r.bin_sum = bin_total[it.bin_index];
            r.bin_sum_squares = bin_square[it.bin_index];
            r.bin_mean = clamp_mean(bin_total[it.bin_index], bin_count[it.bin_index]);
        end
        r.total_entries = n_taken;
        r.total_sum = sum_taken;
        r.positive_losses = n_positive;
        r.overall_mean = clamp_mean(sum_taken, n_taken);
        return r;
    endfunction

    // Record of whether the last rising edge completed an input transfer.
    logic o_ready_seen = 1'b0;

    // Driver: presents queued samples, holding valid until the transfer.
    always @(negedge i_clk) begin
        if (!i_valid || o_ready_seen) begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_data <= sample_queue.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Predictor: every input transfer updates the shadow state.
    always @(posedge i_clk) begin
        o_ready_seen <= i_valid && o_ready && i_rst_n;
        if (i_rst_n && i_valid && o_ready) begin
            expected_queue.insert(expected_queue.size(), histogram_step(i_data));
            if (i_data.kind == KIND_FILL) begin
                if (expected_queue[$].bin_hit == -9'sd1) fills_missed++;
                else fills_hit++;
            end else begin
                reads_done++;
            end
        end
    end

    // Monitor: compares each output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                mismatches++;
            end else begin
                want = expected_queue.pop_front();
                if (want.bin_hit !== o_data.bin_hit ||
                    want.bin_entries !== o_data.bin_entries ||
                    want.bin_sum !== o_data.bin_sum ||
                    want.bin_sum_squares !== o_data.bin_sum_squares ||
                    want.bin_mean !== o_data.bin_mean ||
                    want.total_entries !== o_data.total_entries ||
                    want.total_sum !== o_data.total_sum ||
                    want.positive_losses !== o_data.positive_losses ||
                    want.overall_mean !== o_data.overall_mean) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, o_data);
                    mismatches++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_RANGE_LOW: edge_low = val;
            REG_BIN_WIDTH: width_q = val[30:0];
            REG_BINS:      nbins_q = val[8:0];
            default: ;
        endcase
    endtask

    // Waits for every queued sample and prediction to drain, then settles.
    task automatic drain();
        while (sample_queue.size() != 0 || i_valid || expected_queue.size() != 0)
            @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic t_in fill_item(logic signed [31:0] x, logic signed [23:0] y);
        t_in it;
        it = '0;
        it.kind = KIND_FILL;
        it.slant = x;
        it.energy_loss = y;
        it.bin_index = 8'($urandom);
        return it;
    endfunction

    function automatic t_in read_item(logic [7:0] b);
        t_in it;
        it.kind = ~KIND_FILL;
        it.slant = $urandom;
        it.energy_loss = 24'($urandom);
        it.bin_index = b;
        return it;
    endfunction

    // Mostly in-range fills near the configured window, some noise and reads.
    task automatic random_phase(input int count);
        longint span;
        longint x;
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            span = longint'(width_q) * ((nbins_q > NBINS) ? NBINS : nbins_q);
            if (k < 25) begin
                add_item(read_item(8'($urandom)));
            end else if (k < 85) begin
                x = longint'(edge_low) + (({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF)
                    % ((span > 0) ? span + 2 : 1)) - 1;
                add_item(fill_item(x[31:0],
                    ($urandom_range(9) == 0) ? {1'b0, {23{1'b1}}} : 24'($urandom)));
            end else begin
                add_item(fill_item($urandom, 24'($urandom)));
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_RANGE_LOW;
        i_cfg_data = '0;
        for (int b = 0; b < NBINS; b++) begin
            bin_count[b] = '0;
            bin_total[b] = '0;
            bin_square[b] = '0;
        end
        n_taken = '0;
        sum_taken = '0;
        n_positive = '0;
        edge_low = '0;
        width_q = 31'd4096;
        nbins_q = 9'd256;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes and the default binning.
        send_idle_pct = 10;
        recv_idle_pct = 80;
        add_item(read_item(8'd0));
        add_item(fill_item(32'sd0, 24'sh7FFFFF));
        add_item(fill_item(32'sd0, 24'sh7FFFFF));
        add_item(fill_item(32'sd4095, 24'sh800000));
        add_item(fill_item(32'sd1048575, 24'sd0));
        add_item(fill_item(32'sd1048576, 24'sd5));
        add_item(fill_item(-32'sd1, 24'sd7));
        add_item(fill_item(32'h7FFFFFFF, 24'sd1));
        add_item(fill_item(32'h80000000, -24'sd1));
        add_item(read_item(8'd0));
        add_item(read_item(8'd255));
        add_item(read_item(8'd17));
        drain();

        // Single bin of full width, extreme low edge: overflowing ranges.
        write_reg(REG_RANGE_LOW, 32'h80000000);
        write_reg(REG_BIN_WIDTH, 32'h7FFFFFFF);
        write_reg(REG_BINS, 32'd1);
        add_item(fill_item(32'h80000000, 24'sd3));
        add_item(fill_item(32'h7FFFFFFE, -24'sd3));
        add_item(fill_item(32'h7FFFFFFF, 24'sd9));
        add_item(read_item(8'd0));
        drain();

        // Zero width and zero bins drop every fill; oversized bin count clamps.
        write_reg(REG_BIN_WIDTH, 32'd0);
        add_item(fill_item(32'h80000000, 24'sd1));
        drain();
        write_reg(REG_BIN_WIDTH, 32'd1);
        write_reg(REG_BINS, 32'd0);
        add_item(fill_item(32'h80000000, 24'sd1));
        drain();
        write_reg(REG_BINS, 32'h1FF);
        write_reg(REG_RANGE_LOW, 32'h7FFFFFFF);
        add_item(fill_item(32'h7FFFFFFF, 24'sd2));
        add_item(read_item(8'd0));
        drain();

        // Random phases under varied settings and idling patterns.
        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                send_idle_pct = 80;
                recv_idle_pct = 10;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_RANGE_LOW, (p == 5) ? 32'h7FFF0000 : $urandom_range(0, 8192) - 4096);
            write_reg(REG_BIN_WIDTH, (p % 3 == 0) ? 32'd1 : $urandom_range(1, 65536));
            write_reg(REG_BINS, (p == 1) ? 32'd256 : $urandom_range(1, 300));
            random_phase(275);
            drain();
        end

        $display("Covered %0d in-range fills, %0d dropped fills and %0d bin reads.",
                 fills_hit, fills_missed, reads_done);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
design/pha_pkg.sv
design/pha_div.sv
design/profile_histogram_accumulator_unit.sv
design/pha_checker.sv
tb/tb.sv
